@@ sv/bha_pkg.sv @@
// ----------------------------------------------------------------------------
// Block heap allocator package
// Shared types and constants for the block heap allocator and its
// shared multiply unit.
// ----------------------------------------------------------------------------
package bha_pkg;

  // Default geometry of the heap
  localparam int HeapBytesDef  = 512;
  localparam int BlockBytesDef = 16;

  // Handle encoding
  localparam logic [15:0] HandleBase = 16'h8000;
  localparam logic [15:0] OffsetMask = 16'h7FFF;
  localparam logic [15:0] HdrBytes   = 16'd2;

  // Requested action
  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_QUERY   = 2'd3
  } action_e;

  // Operation of the shared multiply unit
  typedef enum logic {
    MUL_DIV_BLOCK   = 1'b0,  // floor(x / block size) by reciprocal
    MUL_TIMES_BLOCK = 1'b1   // x * block size
  } mul_op_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] handle;
    logic [15:0] request_bytes;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_handle;
    logic [15:0] usable_bytes;
  } out_item_t;

endpackage

@@ sv/bha_mul_unit.sv @@
// ----------------------------------------------------------------------------
// Block heap allocator shared multiply unit
// One registered multiplier that either scales by the block size or divides
// by it through a rounded-up reciprocal. The result is registered for the next cycle.
// ----------------------------------------------------------------------------
module bha_mul_unit
  import bha_pkg::*;
#(
  parameter int HEAP_BYTES  = HeapBytesDef,
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic                                                      clk_i,
  input  mul_op_e                                                   op_i,
  input  logic [$clog2((HEAP_BYTES / BLOCK_BYTES + 1) * BLOCK_BYTES)-1:0] opd_i,
  output logic [$clog2((HEAP_BYTES / BLOCK_BYTES + 1) * BLOCK_BYTES)-1:0] res_o
);

  localparam int NBLK   = HEAP_BYTES / BLOCK_BYTES;
  localparam int OpW    = $clog2((NBLK + 1) * BLOCK_BYTES);
  localparam int LogBlk = $clog2(BLOCK_BYTES);
  localparam int FacW   = OpW + 2;
  localparam int ProdW  = OpW + FacW;
  localparam int Shift  = OpW + LogBlk;
  // floor(2^Shift / block) + 1 gives an exact quotient for every operand
  localparam logic [FacW-1:0] Recip  = FacW'((1 << Shift) / BLOCK_BYTES + 1);
  localparam logic [FacW-1:0] BlkFac = FacW'(BLOCK_BYTES);

  logic [FacW-1:0]  fac;
  logic [ProdW-1:0] prod;
  logic [OpW-1:0]   res_q;

  // Select the factor and multiply
  always_comb begin
    unique case (op_i)
      MUL_DIV_BLOCK:   fac = Recip;
      MUL_TIMES_BLOCK: fac = BlkFac;
      default:         fac = BlkFac;
    endcase
    prod = ProdW'(opd_i) * ProdW'(fac);
  end

  // Register the scaled or shifted product
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      MUL_DIV_BLOCK:   res_q <= OpW'(prod >> Shift);
      MUL_TIMES_BLOCK: res_q <= prod[OpW-1:0];
      default:         res_q <= prod[OpW-1:0];
    endcase
  end

  assign res_o = res_q;

endmodule

@@ sv/block_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Block heap allocator
// First-fit allocator over a heap cut into fixed blocks: allocate, free,
// reallocate in place or anew, and usable size query.
// ----------------------------------------------------------------------------
// Usage:
//   One transaction on the input channel (in_valid_i/in_ready_o, in_data_i)
//   gives exactly one transaction on the output channel (out_valid_o/
//   out_ready_i, out_data_o). in_ready_o is high only while the sequencer
//   is idle; one request is worked at a time.
//   Every request first decodes the handle and sizes the request through
//   the shared multiplier (S_DIV_OFF, S_MUL_OFF, S_DIV_NEED, S_DISPATCH).
//   Allocate then walks the block table from the scan hint, one entry per
//   cycle, jumping over used runs. Free clears one table entry per cycle.
//   A growing reallocate does both. These rates come from the table's
//   single read and write port. After reset the run length table is swept
//   to zero with in_ready_o low. A result waits in the output register
//   while the receiver stalls; the sequencer holds in its final state until
//   that register is free, and then takes the next request.
// ----------------------------------------------------------------------------
module block_heap_allocator_unit
  import bha_pkg::*;
#(
  parameter int HEAP_BYTES  = HeapBytesDef,
  parameter int BLOCK_BYTES = BlockBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int NBLK = HEAP_BYTES / BLOCK_BYTES;
  localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;   // block index
  localparam int LW   = $clog2(NBLK + 1);                // run length
  localparam int NW   = $clog2(NBLK + 2);                // block count
  localparam int PTW  = $clog2(2 * NBLK);                // scan pointer
  localparam int WW   = $clog2((HEAP_BYTES + 3) / 4 + 1);
  localparam int OpW  = $clog2((NBLK + 1) * BLOCK_BYTES);
  localparam logic [16:0] FitLimit = 17'((NBLK + 1) * BLOCK_BYTES);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'h0001,
    S_IDLE     = 14'h0002,
    S_DIV_OFF  = 14'h0004,
    S_MUL_OFF  = 14'h0008,
    S_DIV_NEED = 14'h0010,
    S_DISPATCH = 14'h0020,
    S_SCAN     = 14'h0040,
    S_HANDLE   = 14'h0080,
    S_HANDLE2  = 14'h0100,
    S_RE_LEN   = 14'h0200,
    S_FREE_LEN = 14'h0400,
    S_FREE_CLR = 14'h0800,
    S_QUERY    = 14'h1000,
    S_DONE     = 14'h2000
  } state_e;

  // Control state
  state_e         state_q, state_d;
  logic [BW-1:0]  wptr_q, wptr_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic [BW-1:0]  hint_q, hint_d;
  logic [PTW-1:0] ptr_q, ptr_d;
  logic           grow_q, grow_d;
  logic           out_valid_q, out_valid_d;

  // Payload state
  in_item_t       in_q, in_d;
  logic [BW-1:0]  blk_q, blk_d;
  logic           blk_ok_q, blk_ok_d;
  logic [NW-1:0]  need_q, need_d;
  logic [BW-1:0]  start_q, start_d;
  logic [15:0]    res_hdl_q, res_hdl_d;
  logic [15:0]    usable_q, usable_d;
  out_item_t      out_q, out_d;

  // Block table memories
  logic [LW-1:0]  rl_mem [NBLK];
  logic [WW-1:0]  rw_mem [NBLK];
  logic           rl_we, rw_we;
  logic [BW-1:0]  rl_waddr, rw_waddr, rl_raddr;
  logic [LW-1:0]  rl_wdata, rl_rdata_q;
  logic [WW-1:0]  rw_wdata, rw_rdata_q;

  // Shared multiplier
  mul_op_e        mul_op;
  logic [OpW-1:0] mul_opd, mul_res;

  // Decoded request
  logic [15:0]    off16;
  logic           off_in_range;
  logic [16:0]    numer;
  logic           need_fit;
  logic [16:0]    words_sum;
  logic [WW-1:0]  words;
  logic [15:0]    keep_hdl;

  // Scan, free and shrink helpers
  logic [PTW-1:0] len_ext, nxt, fend, tail_lo, tail_hi, blk_end;
  logic [NW-1:0]  cnt_inc;
  logic [BW-1:0]  scan_start;

  bha_mul_unit #(
    .HEAP_BYTES  (HEAP_BYTES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_mul (
    .clk_i (clk_i),
    .op_i  (mul_op),
    .opd_i (mul_opd),
    .res_o (mul_res)
  );

  // Decode handle offset and request sizes
  always_comb begin
    off16        = (in_q.handle & OffsetMask) - HdrBytes;
    off_in_range = off16 < 16'(HEAP_BYTES);
    numer        = 17'(in_q.request_bytes) + 17'(BLOCK_BYTES + 1);
    need_fit     = numer < FitLimit;
    words_sum    = 17'(in_q.request_bytes) + 17'd5;
    words        = WW'(words_sum[16:2]);
    keep_hdl     = HandleBase + off16 + HdrBytes;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    cnt_d       = cnt_q;
    hint_d      = hint_q;
    ptr_d       = ptr_q;
    grow_d      = grow_q;
    out_valid_d = out_valid_q;
    in_d        = in_q;
    blk_d       = blk_q;
    blk_ok_d    = blk_ok_q;
    need_d      = need_q;
    start_d     = start_q;
    res_hdl_d   = res_hdl_q;
    usable_d    = usable_q;
    out_d       = out_q;

    rl_we    = 1'b0;
    rl_waddr = wptr_q;
    rl_wdata = '0;
    rl_raddr = blk_q;
    rw_we    = 1'b0;
    rw_waddr = start_q;
    rw_wdata = words;
    mul_op   = MUL_DIV_BLOCK;
    mul_opd  = '0;

    len_ext    = PTW'(rl_rdata_q);
    nxt        = ptr_q + PTW'(1);
    cnt_inc    = cnt_q + NW'(1);
    scan_start = (cnt_q == '0) ? ptr_q[BW-1:0] : start_q;
    blk_end    = PTW'(blk_q) + len_ext;
    fend       = blk_end;
    tail_lo    = PTW'(blk_q) + PTW'(need_q);
    tail_hi    = (blk_end > PTW'(NBLK)) ? PTW'(NBLK) : blk_end;

    // Drop the output transaction once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        rl_we  = 1'b1;
        wptr_d = wptr_q + BW'(1);
        if (wptr_q == BW'(NBLK - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          in_d      = in_data_i;
          res_hdl_d = '0;
          usable_d  = '0;
          state_d   = S_DIV_OFF;
        end
      end

      // Block index of the handle offset
      S_DIV_OFF: begin
        mul_op  = MUL_DIV_BLOCK;
        mul_opd = off16[OpW-1:0];
        state_d = S_MUL_OFF;
      end

      // Scale back to check for a block start
      S_MUL_OFF: begin
        blk_d   = mul_res[BW-1:0];
        mul_op  = MUL_TIMES_BLOCK;
        mul_opd = mul_res;
        state_d = S_DIV_NEED;
      end

      // Blocks needed by the request
      S_DIV_NEED: begin
        blk_ok_d = off_in_range && (mul_res == off16[OpW-1:0]);
        mul_op   = MUL_DIV_BLOCK;
        mul_opd  = numer[OpW-1:0];
        state_d  = S_DISPATCH;
      end

      S_DISPATCH: begin
        need_d = need_fit ? NW'(mul_res) : NW'(NBLK + 1);
        unique case (in_q.action)
          ACT_ALLOC: begin
            rl_raddr = hint_q;
            ptr_d    = PTW'(hint_q);
            cnt_d    = '0;
            grow_d   = 1'b0;
            state_d  = S_SCAN;
          end
          ACT_FREE: begin
            state_d = blk_ok_q ? S_FREE_LEN : S_DONE;
          end
          ACT_REALLOC: begin
            state_d = blk_ok_q ? S_RE_LEN : S_DONE;
          end
          ACT_QUERY: begin
            state_d = blk_ok_q ? S_QUERY : S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      // First-fit walk, one table entry per cycle
      S_SCAN: begin
        if (rl_rdata_q == '0) begin
          if (cnt_inc == need_q) begin
            rl_we    = 1'b1;
            rl_waddr = scan_start;
            rl_wdata = LW'(need_q);
            rw_we    = 1'b1;
            rw_waddr = scan_start;
            hint_d   = scan_start;
            start_d  = scan_start;
            state_d  = S_HANDLE;
          end else begin
            cnt_d   = cnt_inc;
            start_d = scan_start;
          end
        end else begin
          cnt_d = '0;
          nxt   = ptr_q + len_ext;
        end
        if (state_d == S_SCAN) begin
          if (nxt >= PTW'(NBLK)) begin
            state_d = S_DONE;
          end else begin
            rl_raddr = nxt[BW-1:0];
            ptr_d    = nxt;
          end
        end
      end

      S_HANDLE: begin
        mul_op  = MUL_TIMES_BLOCK;
        mul_opd = OpW'(start_q);
        state_d = S_HANDLE2;
      end

      // Form the new handle, then release the old run on a move
      S_HANDLE2: begin
        res_hdl_d = HandleBase + 16'(mul_res) + HdrBytes;
        if (grow_q) begin
          rl_raddr = blk_q;
          state_d  = S_FREE_LEN;
        end else begin
          state_d = S_DONE;
        end
      end

      S_RE_LEN: begin
        if (NW'(rl_rdata_q) == need_q) begin
          res_hdl_d = keep_hdl;
          state_d   = S_DONE;
        end else if (need_q < NW'(rl_rdata_q)) begin
          // Shrink in place and clear the tail
          rl_we     = 1'b1;
          rl_waddr  = blk_q;
          rl_wdata  = LW'(need_q);
          rw_we     = 1'b1;
          rw_waddr  = blk_q;
          res_hdl_d = keep_hdl;
          if (tail_hi > tail_lo) begin
            wptr_d  = tail_lo[BW-1:0];
            cnt_d   = NW'(tail_hi - tail_lo);
            state_d = S_FREE_CLR;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          rl_raddr = hint_q;
          ptr_d    = PTW'(hint_q);
          cnt_d    = '0;
          grow_d   = 1'b1;
          state_d  = S_SCAN;
        end
      end

      S_FREE_LEN: begin
        if (fend <= PTW'(NBLK)) begin
          if (blk_q < hint_q) begin
            hint_d = blk_q;
          end
          if (rl_rdata_q != '0) begin
            wptr_d  = blk_q;
            cnt_d   = NW'(rl_rdata_q);
            state_d = S_FREE_CLR;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_FREE_CLR: begin
        rl_we  = 1'b1;
        wptr_d = wptr_q + BW'(1);
        cnt_d  = cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          state_d = S_DONE;
        end
      end

      S_QUERY: begin
        usable_d = (16'(rw_rdata_q) << 2) - HdrBytes;
        state_d  = S_DONE;
      end

      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_handle = res_hdl_q;
          out_d.usable_bytes  = usable_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      wptr_q      <= '0;
      cnt_q       <= '0;
      hint_q      <= '0;
      ptr_q       <= '0;
      grow_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      cnt_q       <= cnt_d;
      hint_q      <= hint_d;
      ptr_q       <= ptr_d;
      grow_q      <= grow_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q      <= in_d;
    blk_q     <= blk_d;
    blk_ok_q  <= blk_ok_d;
    need_q    <= need_d;
    start_q   <= start_d;
    res_hdl_q <= res_hdl_d;
    usable_q  <= usable_d;
    out_q     <= out_d;
  end

  // Run length table
  always_ff @(posedge clk_i) begin
    if (rl_we) begin
      rl_mem[rl_waddr] <= rl_wdata;
    end
    rl_rdata_q <= rl_mem[rl_raddr];
  end

  // Word count table
  always_ff @(posedge clk_i) begin
    if (rw_we) begin
      rw_mem[rw_waddr] <= rw_wdata;
    end
    rw_rdata_q <= rw_mem[blk_q];
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/block_heap_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block heap allocator testbench
// Drives allocate, free, reallocate and size query transactions into the
// allocator under random idling on both channels. A scoreboard keeps its own
// copy of the block table, predicts every result and compares it field by
// field with what comes out of the block.
// ----------------------------------------------------------------------------
module block_heap_allocator_unit_test;
  import bha_pkg::*;

  localparam int HEAP_BYTES   = HeapBytesDef;
  localparam int BLOCK_BYTES  = BlockBytesDef;
  localparam int NBLK         = HEAP_BYTES / BLOCK_BYTES;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 2 * NBLK + 20;
  localparam int CYCLE_LIMIT  = 800000;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow block table and queue of predicted results
  // --------------------------------------------------------------------------
  class heap_scoreboard;
    logic [5:0] run_len   [NBLK];
    logic [7:0] run_words [NBLK];
    bit         words_set [NBLK];  // word count written at least once
    logic [4:0] hint;
    out_item_t  expected_q [$];
    int         errors;

    function new();
      hint   = '0;
      errors = 0;
      for (int b = 0; b < NBLK; b++) begin
        run_len[b]   = '0;
        run_words[b] = '0;
        words_set[b] = 1'b0;
      end
    endfunction

    function int blocks_for(int bytes);
      return (bytes + BLOCK_BYTES + 1) / BLOCK_BYTES;
    endfunction

    function logic [7:0] words_for(int bytes);
      return 8'((bytes + 5) / 4);
    endfunction

    // Map a handle to a block index; fail off the heap or off a block start
    function bit decode(logic [15:0] handle, output int blk);
      logic [15:0] off;
      off = (handle & OffsetMask) - HdrBytes;
      blk = int'(off) / BLOCK_BYTES;
      return (int'(off) < HEAP_BYTES) && (int'(off) % BLOCK_BYTES == 0);
    endfunction

    function logic [15:0] make_handle(int blk);
      return HandleBase + 16'(blk * BLOCK_BYTES) + HdrBytes;
    endfunction

    // First-fit scan from the hint, jumping over used runs
    function logic [15:0] alloc_run(int bytes);
      int need;
      int start;
      int count;
      int skip;
      need  = blocks_for(bytes);
      start = 0;
      count = 0;
      skip  = 0;
      for (int i = int'(hint); i < NBLK; i++) begin
        if (skip > 0) begin
          skip--;
        end else if (run_len[i] == 0) begin
          if (count == 0) start = i;
          count++;
          if (count == need) begin
            run_len[start]   = 6'(need);
            run_words[start] = words_for(bytes);
            words_set[start] = 1'b1;
            hint             = 5'(start);
            return make_handle(start);
          end
        end else begin
          skip  = int'(run_len[i]) - 1;
          count = 0;
        end
      end
      return '0;
    endfunction

    // Clear a run and pull the hint down to it
    function void free_run(int blk);
      int len;
      len = int'(run_len[blk]);
      if (blk + len <= NBLK) begin
        for (int k = 0; k < len; k++) run_len[blk + k] = '0;
        if (blk < int'(hint)) hint = 5'(blk);
      end
    endfunction

    // Predict the result of an accepted request and update the table
    function void note_input(in_item_t it);
      out_item_t want;
      int        blk;
      int        old_len;
      int        nb;
      want = '0;
      case (it.action)
        ACT_ALLOC: begin
          want.result_handle = alloc_run(int'(it.request_bytes));
        end
        ACT_FREE: begin
          if (decode(it.handle, blk)) free_run(blk);
        end
        ACT_REALLOC: begin
          if (decode(it.handle, blk)) begin
            old_len = int'(run_len[blk]);
            nb      = blocks_for(int'(it.request_bytes));
            if (nb == old_len) begin
              want.result_handle = make_handle(blk);
            end else if (nb < old_len) begin
              // shrink in place and release the tail
              run_len[blk]   = 6'(nb);
              run_words[blk] = words_for(int'(it.request_bytes));
              words_set[blk] = 1'b1;
              for (int k = blk + nb; k < blk + old_len && k < NBLK; k++) run_len[k] = '0;
              want.result_handle = make_handle(blk);
            end else begin
              want.result_handle = alloc_run(int'(it.request_bytes));
              if (want.result_handle != '0) free_run(blk);
            end
          end
        end
        ACT_QUERY: begin
          if (decode(it.handle, blk))
            want.usable_bytes = {6'b0, run_words[blk], 2'b00} - HdrBytes;
        end
      endcase
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one output transaction with the oldest prediction
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.result_handle !== want.result_handle)
        report($sformatf("result_handle %h, want %h", got.result_handle, want.result_handle));
      if (got.usable_bytes !== want.usable_bytes)
        report($sformatf("usable_bytes %h, want %h", got.usable_bytes, want.usable_bytes));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  bit             hold_req    = 1'b0;
  int             tx_idle_pct = 30;
  int             rx_idle_pct = 30;
  heap_scoreboard sb;

  block_heap_allocator_unit #(
    .HEAP_BYTES (HEAP_BYTES),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Idle length: mostly none or short, now and then long
  function automatic int idle_len(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic in_item_t make_item(action_e act, logic [15:0] handle,
                                         logic [15:0] bytes);
    in_item_t it;
    it.action        = act;
    it.handle        = handle;
    it.request_bytes = bytes;
    return it;
  endfunction

  // Handle of a block start; the top bit is ignored by the block, so drop it now and then
  function automatic logic [15:0] handle_of(int blk);
    logic [15:0] h;
    h = sb.make_handle(blk);
    if ($urandom_range(7) == 0) h[15] = 1'b0;
    return h;
  endfunction

  function automatic logic [15:0] rand_bytes();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(60));
    if (r < 90) return 16'($urandom_range(520, 61));
    return 16'($urandom);
  endfunction

  // Mostly requests on live runs, some on arbitrary handles
  function automatic in_item_t random_item();
    in_item_t it;
    int       live [$];
    int       written [$];
    int       used;
    int       r;
    int       blk;
    used = 0;
    for (int b = 0; b < NBLK; b++) begin
      if (sb.run_len[b] != 0) begin
        live.push_back(b);
        used += int'(sb.run_len[b]);
      end
      if (sb.words_set[b]) written.push_back(b);
    end
    it.handle        = 16'($urandom);
    it.request_bytes = rand_bytes();
    // lean toward freeing once the heap gets crowded
    r = $urandom_range(99);
    if (r < (used > 20 ? 25 : 45)) it.action = ACT_ALLOC;
    else if (r < (used > 20 ? 70 : 65)) it.action = ACT_FREE;
    else if (r < 85) it.action = ACT_REALLOC;
    else it.action = ACT_QUERY;
    case (it.action)
      ACT_FREE, ACT_REALLOC: begin
        if (live.size() > 0 && $urandom_range(9) < 8)
          it.handle = handle_of(live[$urandom_range(live.size() - 1)]);
        else if ($urandom_range(1) == 0)
          it.handle = handle_of($urandom_range(NBLK - 1));
      end
      ACT_QUERY: begin
        if (written.size() > 0 && $urandom_range(99) < 85)
          it.handle = handle_of(written[$urandom_range(written.size() - 1)]);
        // never query a word count that was never written; misalign instead
        if (sb.decode(it.handle, blk) && !sb.words_set[blk]) it.handle = it.handle + 16'd1;
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    gap = idle_len(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: check results, stall at random, hold off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = idle_len(rx_idle_pct);
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Bound the run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full heap, oversize, keep, grow, shrink, bad handles,
    // double free, reallocate of a free block
    send_item(make_item(ACT_ALLOC,   16'h0000, 16'd510));
    send_item(make_item(ACT_QUERY,   16'h8002, 16'h0000));
    send_item(make_item(ACT_ALLOC,   16'h0000, 16'd0));
    send_item(make_item(ACT_FREE,    16'h8002, 16'h0000));
    send_item(make_item(ACT_ALLOC,   16'hFFFF, 16'd0));
    send_item(make_item(ACT_ALLOC,   16'h0000, 16'hFFFF));
    send_item(make_item(ACT_QUERY,   16'h0002, 16'h0000));
    send_item(make_item(ACT_REALLOC, 16'h8002, 16'd14));
    send_item(make_item(ACT_QUERY,   16'h8002, 16'h0000));
    send_item(make_item(ACT_REALLOC, 16'h8002, 16'd100));
    send_item(make_item(ACT_REALLOC, 16'h8012, 16'd20));
    send_item(make_item(ACT_QUERY,   16'h8012, 16'hFFFF));
    send_item(make_item(ACT_FREE,    16'h8003, 16'h0000));
    send_item(make_item(ACT_FREE,    16'h8202, 16'h0000));
    send_item(make_item(ACT_FREE,    16'h0000, 16'h0000));
    send_item(make_item(ACT_REALLOC, 16'hFFFF, 16'd40));
    send_item(make_item(ACT_QUERY,   16'h8203, 16'h0000));
    send_item(make_item(ACT_FREE,    16'h8002, 16'h0000));
    send_item(make_item(ACT_REALLOC, 16'h8142, 16'd30));
    send_item(make_item(ACT_ALLOC,   16'h0000, 16'd600));
    send_item(make_item(ACT_FREE,    16'h8012, 16'h0000));
    send_item(make_item(ACT_FREE,    16'h8032, 16'h0000));
    send_item(make_item(ACT_QUERY,   16'h8032, 16'h0000));
    send_item(make_item(ACT_REALLOC, 16'h8032, 16'd0));
    send_item(make_item(ACT_ALLOC,   16'hFFFF, 16'hFFFF));
    wait_drained();

    // Random segments with varying idle pressure
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin tx_idle_pct = 30; rx_idle_pct = 30; end
        1: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 60; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 10; rx_idle_pct = 60; end
      endcase
      // long receiver hold-off while requests keep coming
      if (seg == 2) hold_req = 1'b1;
      for (int n = 0; n < 100; n++) send_item(random_item());
      if (seg == 4) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bha_pkg.sv
sv/bha_mul_unit.sv
sv/block_heap_allocator_unit.sv
tb/block_heap_allocator_unit_test.sv
